[rtl/core/nv16_to_nv12_stride_crop_macros.svh]
// Assertion helpers shared by the core RTL.
`ifndef NV16_TO_NV12_STRIDE_CROP_MACROS_SVH
`define NV16_TO_NV12_STRIDE_CROP_MACROS_SVH

// Check cons in the same cycle as ante.
`define NVSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nvsc assertion failed");

// Check cons in the cycle after ante.
`define NVSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nvsc assertion failed");

`endif

[rtl/core/nvsc_pkg.sv]
`timescale 1ns / 1ps

package nvsc_pkg;

	localparam int BYTE_W       = 8;
	localparam int CFG_W        = 13;
	localparam int CNT_W        = 12;
	localparam int IDX_W        = 3;
	localparam int MAX_LINE_DEF = 4096;

	localparam logic [CFG_W-1:0] STRIDE_MIN = 13'd1;
	localparam logic [CFG_W-1:0] ROWS_MIN   = 13'd2;
	localparam logic [CFG_W-1:0] DIM_MAX    = 13'd4096;
	localparam logic [CFG_W-1:0] RST_DIM    = 13'd640;

	typedef enum logic [IDX_W-1:0] {
		REG_ACTIVE_WIDTH,
		REG_ACTIVE_HEIGHT,
		REG_ROW_STRIDE,
		REG_PLANE_ROWS,
		REG_SOURCE_FORMAT
	} reg_idx_t;

	typedef enum logic {
		FMT_420,
		FMT_422
	} fmt_t;

	// Frame limits derived from the configuration registers.
	typedef struct packed {
		fmt_t             fmt;
		logic [CFG_W-1:0] stride;
		logic [CFG_W-1:0] ew;
		logic [CFG_W-1:0] eh;
		logic [CFG_W-1:0] luma_len;
		logic [CFG_W-1:0] chroma_len;
		logic [CFG_W-1:0] crows2;
		logic [CNT_W-1:0] crows;
	} lim_t;

	// What to do with the word at the current buffer position.
	typedef struct packed {
		logic             emit;
		logic             store;
		logic             avg;
		logic             fend;
		logic [CNT_W-1:0] col;
	} dec_t;

endpackage

[rtl/core/nvsc_src_if.sv]
`timescale 1ns / 1ps

interface nvsc_src_if import nvsc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] src_byte;

	modport source (output valid, output src_byte, input ready);
	modport sink (input valid, input src_byte, output ready);
endinterface

[rtl/core/nvsc_dst_if.sv]
`timescale 1ns / 1ps

interface nvsc_dst_if import nvsc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              frame_end;

	modport source (output valid, output out_byte, output frame_end, input ready);
	modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

[rtl/core/nvsc_cfg_if.sv]
`timescale 1ns / 1ps

interface nvsc_cfg_if import nvsc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	logic [CFG_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/nv16_to_nv12_stride_crop.sv]
`timescale 1ns / 1ps

// Strided NV16/NV12 frame buffer to packed NV12. One source byte is taken per clock in
// memory order while the output is not stalled, luma plane then chroma plane, padding
// included; padding is dropped and, for a 4:2:2 source, each odd chroma row is averaged
// with the even row held in a MAX_LINE byte line buffer (one write and one read port).
// Sustained rate is one byte per clock in both directions while dst.ready holds; a kept
// byte is registered with the line buffer read register, then in the output register.
// The line buffer needs no clearing after reset. Write configuration only while no
// frame is in flight.
module nv16_to_nv12_stride_crop import nvsc_pkg::*; #(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	nvsc_src_if.sink   src,
	nvsc_dst_if.source dst,
	nvsc_cfg_if.sink   cfg
);

	lim_t lim;
	dec_t dec;
	logic take;
	logic accept;

	assign src.ready = take;
	assign accept    = src.valid && take;

	nvsc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.lim    (lim)
	);

	nvsc_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.lim    (lim),
		.dec    (dec)
	);

	nvsc_line #(
		.MAX_LINE (MAX_LINE)
	) u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.dec      (dec),
		.src_byte (src.src_byte),
		.take     (take),
		.dst      (dst)
	);

endmodule

[rtl/core/nvsc_cfg.sv]
`timescale 1ns / 1ps

module nvsc_cfg import nvsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	nvsc_cfg_if.sink    cfg,
	output lim_t        lim
);

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [CFG_W-1:0] stride_q;
	logic [CFG_W-1:0] rows_q;
	fmt_t             fmt_q;

	logic [CFG_W-1:0] stride;
	logic [CFG_W-1:0] prows;
	logic [CFG_W-1:0] eh;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_DIM;
			height_q <= RST_DIM;
			stride_q <= RST_DIM;
			rows_q   <= RST_DIM;
			fmt_q    <= FMT_420;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_ACTIVE_WIDTH:  width_q  <= cfg.data;
				REG_ACTIVE_HEIGHT: height_q <= cfg.data;
				REG_ROW_STRIDE:    stride_q <= cfg.data;
				REG_PLANE_ROWS:    rows_q   <= cfg.data;
				REG_SOURCE_FORMAT: fmt_q    <= fmt_t'(cfg.data[0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		stride = (stride_q < STRIDE_MIN) ? STRIDE_MIN :
			(stride_q > DIM_MAX) ? DIM_MAX : stride_q;
		prows  = (rows_q < ROWS_MIN) ? ROWS_MIN :
			(rows_q > DIM_MAX) ? DIM_MAX : rows_q;
		eh     = (height_q < prows) ? height_q : prows;

		lim.fmt        = fmt_q;
		lim.stride     = stride;
		lim.ew         = (width_q < stride) ? width_q : stride;
		lim.eh         = eh;
		lim.luma_len   = prows;
		lim.chroma_len = (fmt_q == FMT_420) ? (prows >> 1) : prows;
		lim.crows      = eh[CFG_W-1:1];
		lim.crows2     = {eh[CFG_W-1:1], 1'b0};
	end

endmodule

[rtl/core/nvsc_scan.sv]
`timescale 1ns / 1ps

module nvsc_scan import nvsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  lim_t lim,
	output dec_t dec
);

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic             chroma_q;

	logic [CFG_W-1:0] col;
	logic [CFG_W-1:0] row;
	logic [CFG_W-1:0] col_nx;
	logic [CFG_W-1:0] row_nx;
	logic [CFG_W-1:0] crows;
	logic [CFG_W-1:0] plane_len;
	logic             last_col;
	logic             col_in;

	always_comb begin
		col       = {1'b0, col_q};
		row       = {1'b0, row_q};
		col_nx    = col + 13'd1;
		row_nx    = row + 13'd1;
		crows     = {1'b0, lim.crows};
		last_col  = (lim.ew != '0) && (col == lim.ew - 13'd1);
		col_in    = col < lim.ew;
		plane_len = chroma_q ? lim.chroma_len : lim.luma_len;

		dec.emit  = 1'b0;
		dec.store = 1'b0;
		dec.avg   = 1'b0;
		dec.fend  = 1'b0;
		dec.col   = col_q;

		if (!chroma_q) begin
			dec.emit = (row < lim.eh) && col_in;
			dec.fend = (crows == '0) && (row == lim.eh - 13'd1) && last_col;
		end else if (lim.fmt == FMT_420) begin
			dec.emit = (row < crows) && col_in;
			dec.fend = (row == crows - 13'd1) && last_col;
		end else if ((row < lim.crows2) && col_in) begin
			dec.store = !row_q[0];
			dec.emit  = row_q[0];
			dec.avg   = row_q[0];
			dec.fend  = (row == lim.crows2 - 13'd1) && last_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			chroma_q <= 1'b0;
		end else if (accept) begin
			if (col_nx >= lim.stride) begin
				col_q <= '0;
				if (row_nx >= plane_len) begin
					row_q    <= '0;
					chroma_q <= !chroma_q;
				end else begin
					row_q <= row_nx[CNT_W-1:0];
				end
			end else begin
				col_q <= col_nx[CNT_W-1:0];
			end
		end
	end

endmodule

[rtl/core/nvsc_line.sv]
`timescale 1ns / 1ps
`include "nv16_to_nv12_stride_crop_macros.svh"

module nvsc_line import nvsc_pkg::*; #(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  dec_t              dec,
	input  logic [BYTE_W-1:0] src_byte,
	output logic              take,
	nvsc_dst_if.source        dst
);

	localparam int AW = $clog2(MAX_LINE);

	logic [BYTE_W-1:0] mem [MAX_LINE];

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [BYTE_W-1:0] prev_s1;
	logic              in_line_s1;
	logic              avg_s1;
	logic              fend_s1;

	logic              valid_s2;
	logic [BYTE_W-1:0] byte_s2;
	logic              fend_s2;

	logic [AW-1:0]     addr;
	logic              in_line;
	logic              load;
	logic              move_s2;
	logic [BYTE_W-1:0] prev;
	logic [BYTE_W:0]   sum;

	assign addr    = AW'(dec.col);
	assign in_line = {20'd0, dec.col} < 32'(MAX_LINE);
	assign load    = accept && dec.emit;
	assign move_s2 = !valid_s2 || dst.ready;
	assign take    = !valid_s1 || move_s2;
	assign prev    = in_line_s1 ? prev_s1 : '0;
	assign sum     = {1'b0, prev} + {1'b0, byte_s1};

	assign dst.valid     = valid_s2;
	assign dst.out_byte  = byte_s2;
	assign dst.frame_end = fend_s2;

	always_ff @(posedge clk) begin
		if (accept && dec.store && in_line) begin
			mem[addr] <= src_byte;
		end
		if (load && dec.avg && in_line) begin
			prev_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= load;
			end
			if (move_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1    <= src_byte;
			in_line_s1 <= in_line;
			avg_s1     <= dec.avg;
			fend_s1    <= dec.fend;
		end
		if (move_s2 && valid_s1) begin
			byte_s2 <= avg_s1 ? sum[BYTE_W:1] : byte_s1;
			fend_s2 <= fend_s1;
		end
	end

	`NVSC_ASSERT_NOW(a_full_stall, clk, arst_n, valid_s1 && valid_s2 && !dst.ready, !take)
	`NVSC_ASSERT_NEXT(a_load_fills, clk, arst_n, load, valid_s1)
	`NVSC_ASSERT_NEXT(a_hold_s1, clk, arst_n, valid_s1 && !move_s2, valid_s1 && $stable(byte_s1))

endmodule
